>>> hdl/sqs_pkg.sv
`timescale 1ns / 1ps

package sqs_pkg;

	localparam int N_WIDTH_DEF = 20;
	localparam int N_TOTAL_W   = 20;
	localparam int BIDX_W      = 3;
	localparam int BOUNDARY_W  = 21;
	localparam int NUM_BOUND   = 7;

	typedef logic [BIDX_W-1:0] bidx_t;

	localparam bidx_t FIRST_IDX = bidx_t'(1);
	localparam bidx_t LAST_IDX  = bidx_t'(NUM_BOUND);

endpackage

>>> hdl/sqs_size_if.sv
`timescale 1ns / 1ps

interface sqs_size_if;
	import sqs_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [N_TOTAL_W-1:0] n_total;

	modport source (output valid, output n_total, input ready);
	modport sink (input valid, input n_total, output ready);
endinterface

>>> hdl/sqs_bound_if.sv
`timescale 1ns / 1ps

interface sqs_bound_if;
	import sqs_pkg::*;

	logic                  valid;
	logic                  ready;
	bidx_t                 boundary_index;
	logic [BOUNDARY_W-1:0] boundary;
	logic                  last;

	modport source (output valid, output boundary_index, output boundary, output last,
		input ready);
	modport sink (input valid, input boundary_index, input boundary, input last,
		output ready);
endinterface

>>> hdl/sqs_cube_eval.sv
`timescale 1ns / 1ps

// P(x) = x(x+1)(2x+1) on one shared XW x XW multiplier, done follows start via C_LO, C_HI, C_SUM.
module sqs_cube_eval #(
	parameter int XW = 22
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [XW-1:0]     x,
	output logic              done,
	output logic [3*XW-1:0]   p
);
	localparam int PW = 3 * XW;

	typedef enum logic [1:0] {C_IDLE, C_LO, C_HI, C_SUM} cstate_t;

	cstate_t             state_q;
	logic [XW-1:0]       x_q;
	logic [2*XW-1:0]     p1_q;
	logic [2*XW-1:0]     lo_q;
	logic [2*XW-1:0]     hi_q;
	logic [PW-1:0]       p_q;
	logic                done_q;
	logic [XW-1:0]       odd;
	logic [XW-1:0]       mul_a;
	logic [XW-1:0]       mul_b;
	logic [2*XW-1:0]     mul_p;

	assign odd = {x_q[XW-2:0], 1'b1};

	always_comb begin
		case (state_q)
			C_IDLE: begin
				mul_a = x;
				mul_b = x + 1'b1;
			end
			C_LO: begin
				mul_a = p1_q[XW-1:0];
				mul_b = odd;
			end
			C_HI: begin
				mul_a = p1_q[2*XW-1:XW];
				mul_b = odd;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (start) begin
						x_q     <= x;
						p1_q    <= mul_p;
						state_q <= C_LO;
					end
				end
				C_LO: begin
					lo_q    <= mul_p;
					state_q <= C_HI;
				end
				C_HI: begin
					hi_q    <= mul_p;
					state_q <= C_SUM;
				end
				C_SUM: begin
					p_q     <= {hi_q, {XW{1'b0}}} + PW'(lo_q);
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

>>> hdl/square_sum_partition_search.sv
`timescale 1ns / 1ps

// channel    modport  payload                                 role
// size_ch    sink     n_total[19:0]                           one problem size per transaction
// bound_ch   source   boundary_index[2:0] boundary[20:0] last seven boundaries per size
//
// Every S(x) evaluation runs on the shared multiplier in sqs_cube_eval; each binary-search
// probe is a request, that evaluation and a sequencer step in S_SEARCH.
// size_ch.ready is high only while idle; a boundary waiting on bound_ch does not stop
// the next search, which stalls only when its own result finds the output register full.
// arst_n clears the sequencer, the evaluator and the output valid flag.
module square_sum_partition_search #(
	parameter int N_WIDTH = sqs_pkg::N_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	sqs_size_if.sink           size_ch,
	sqs_bound_if.source        bound_ch
);
	import sqs_pkg::*;

	localparam int XW = N_WIDTH + 2;
	localparam int PW = 3 * XW;
	localparam logic signed [XW-1:0] ONE_S = XW'(1);

	typedef enum logic [3:0] {
		S_IDLE, S_WAIT_N, S_WAIT_PREV, S_SEARCH, S_WAIT_MID,
		S_WAIT_L, S_WAIT_R, S_PICK, S_EMIT
	} state_t;

	state_t                  state_q;
	logic [N_WIDTH-1:0]      n_q;
	logic [PW-1:0]           share6_q;
	logic [PW-1:0]           t6_q;
	logic signed [XW-1:0]    left_q;
	logic signed [XW-1:0]    right_q;
	logic signed [XW-1:0]    mid_q;
	logic [N_WIDTH:0]        res_q;
	logic [PW-1:0]           dl_q;
	logic [PW-1:0]           dr_q;
	bidx_t                   k_q;
	logic                    ev_start_q;
	logic [XW-1:0]           ev_x_q;
	logic                    out_valid_q;
	bidx_t                   out_idx_q;
	logic [BOUNDARY_W-1:0]   out_bnd_q;
	logic                    out_last_q;

	logic                    ev_done;
	logic [PW-1:0]           ev_p;
	logic signed [XW-1:0]    span;
	logic signed [XW-1:0]    mid_c;
	logic                    emit_go;

	// P(n) mod 48 from its low nibble, given that P(n) is a multiple of 3
	function automatic logic [5:0] low_rem(input logic [3:0] lo);
		logic [5:0] r;
		case (lo)
			4'd0:    r = 6'd0;
			4'd1:    r = 6'd33;
			4'd2:    r = 6'd18;
			4'd3:    r = 6'd3;
			4'd4:    r = 6'd36;
			4'd5:    r = 6'd21;
			4'd6:    r = 6'd6;
			4'd7:    r = 6'd39;
			4'd8:    r = 6'd24;
			4'd9:    r = 6'd9;
			4'd10:   r = 6'd42;
			4'd11:   r = 6'd27;
			4'd12:   r = 6'd12;
			4'd13:   r = 6'd45;
			4'd14:   r = 6'd30;
			4'd15:   r = 6'd15;
			default: r = 6'd0;
		endcase
		return r;
	endfunction

	function automatic logic [PW-1:0] absd(input logic [PW-1:0] a, input logic [PW-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	sqs_cube_eval #(.XW(XW)) u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ev_start_q),
		.x      (ev_x_q),
		.done   (ev_done),
		.p      (ev_p)
	);

	assign span    = right_q - left_q;
	assign mid_c   = left_q + (span >>> 1);
	assign emit_go = (state_q == S_EMIT) && (!out_valid_q || bound_ch.ready);

	// all compares run on 6*S: targets are scaled, no division needed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ev_start_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			ev_start_q <= 1'b0;
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (bound_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (size_ch.valid) begin
						n_q        <= size_ch.n_total[N_WIDTH-1:0];
						ev_x_q     <= XW'(size_ch.n_total[N_WIDTH-1:0]);
						ev_start_q <= 1'b1;
						state_q    <= S_WAIT_N;
					end
				end
				S_WAIT_N: begin
					if (ev_done) begin
						share6_q   <= (ev_p - PW'(low_rem(ev_p[3:0]))) >> 3;
						k_q        <= FIRST_IDX;
						res_q      <= '0;
						ev_x_q     <= '0;
						ev_start_q <= 1'b1;
						state_q    <= S_WAIT_PREV;
					end
				end
				S_WAIT_PREV: begin
					if (ev_done) begin
						t6_q    <= ev_p + share6_q;
						left_q  <= $signed({1'b0, res_q});
						right_q <= $signed({2'b00, n_q});
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (left_q <= right_q) begin
						mid_q      <= mid_c;
						ev_x_q     <= mid_c;
						ev_start_q <= 1'b1;
						state_q    <= S_WAIT_MID;
					end else if (right_q[XW-1]) begin
						res_q   <= left_q[N_WIDTH:0];
						state_q <= S_EMIT;
					end else begin
						ev_x_q     <= left_q;
						ev_start_q <= 1'b1;
						state_q    <= S_WAIT_L;
					end
				end
				S_WAIT_MID: begin
					if (ev_done) begin
						if (ev_p == t6_q) begin
							res_q   <= mid_q[N_WIDTH:0];
							state_q <= S_EMIT;
						end else if (ev_p < t6_q) begin
							left_q  <= mid_q + ONE_S;
							state_q <= S_SEARCH;
						end else begin
							right_q <= mid_q - ONE_S;
							state_q <= S_SEARCH;
						end
					end
				end
				S_WAIT_L: begin
					if (ev_done) begin
						dl_q       <= absd(ev_p, t6_q);
						ev_x_q     <= right_q;
						ev_start_q <= 1'b1;
						state_q    <= S_WAIT_R;
					end
				end
				S_WAIT_R: begin
					if (ev_done) begin
						dr_q    <= absd(ev_p, t6_q);
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					res_q   <= (dl_q < dr_q) ? left_q[N_WIDTH:0] : right_q[N_WIDTH:0];
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						out_idx_q   <= k_q;
						out_bnd_q   <= BOUNDARY_W'(res_q);
						out_last_q  <= (k_q == LAST_IDX);
						if (k_q == LAST_IDX) begin
							state_q <= S_IDLE;
						end else begin
							k_q        <= bidx_t'(k_q + 1'b1);
							ev_x_q     <= XW'(res_q);
							ev_start_q <= 1'b1;
							state_q    <= S_WAIT_PREV;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign size_ch.ready           = (state_q == S_IDLE);
	assign bound_ch.valid          = out_valid_q;
	assign bound_ch.boundary_index = out_idx_q;
	assign bound_ch.boundary       = out_bnd_q;
	assign bound_ch.last           = out_last_q;

endmodule

>>> hdl/sqs_checker.sv
`timescale 1ns / 1ps

module sqs_checker #(
	parameter int N_WIDTH = sqs_pkg::N_WIDTH_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [sqs_pkg::BIDX_W-1:0]      out_idx,
	input logic [sqs_pkg::BOUNDARY_W-1:0]  out_bnd,
	input logic                            out_last
);
	import sqs_pkg::*;

	localparam logic [BOUNDARY_W:0] BMAX = (BOUNDARY_W + 1)'(1) << N_WIDTH;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after an input transaction");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_idx) && $stable(out_bnd)
			&& $stable(out_last))
		else $error("stalled output transaction changed");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_idx != '0) && (out_last == (out_idx == LAST_IDX)))
		else $error("boundary index and last flag disagree");

	a_bound_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, out_bnd} <= BMAX)
		else $error("boundary beyond n+1");

	a_idle_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> out_last)
		else $error("idle with an unfinished run pending");

endmodule

bind square_sum_partition_search sqs_checker #(.N_WIDTH(N_WIDTH)) u_sqs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (size_ch.valid),
	.in_ready  (size_ch.ready),
	.out_valid (bound_ch.valid),
	.out_ready (bound_ch.ready),
	.out_idx   (bound_ch.boundary_index),
	.out_bnd   (bound_ch.boundary),
	.out_last  (bound_ch.last)
);

>>> tb/sv/square_sum_partition_search_tb.sv
`timescale 1ns / 1ps

module square_sum_partition_search_tb;
	import sqs_pkg::*;

	localparam int          N_BITS       = N_WIDTH_DEF;
	localparam int          RAND_ITEMS   = 100;
	localparam int          CALM_ITEMS   = 20;
	localparam int          HOLD_AT      = 30;
	localparam int          HOLD_CYCLES  = 2000;
	localparam int          DRAIN_CYCLES = 200;
	localparam int          IDLE_LIMIT   = 20000;
	localparam int          MAX_REPORTS  = 10;

	typedef logic [BOUNDARY_W-1:0] bound_t;

	typedef struct packed {
		logic [N_TOTAL_W-1:0]          n;
		logic                          known;
		logic [NUM_BOUND-1:0][BOUNDARY_W-1:0] bounds;
	} size_row_t;

	typedef struct {
		bidx_t  idx;
		bound_t boundary;
		logic   last;
	} bound_rec_t;

	// bounds[0] holds the first boundary
	localparam size_row_t DIR_ROWS [19] = '{
		'{20'd0,       1'b1, {NUM_BOUND{21'd0}}},
		'{20'd1,       1'b1, {NUM_BOUND{21'd0}}},
		'{20'd3,       1'b1, {NUM_BOUND{21'd1}}},
		'{20'd2,       1'b0, '0},
		'{20'd4,       1'b0, '0},
		'{20'd5,       1'b0, '0},
		'{20'd7,       1'b0, '0},
		'{20'd8,       1'b0, '0},
		'{20'd15,      1'b0, '0},
		'{20'd16,      1'b0, '0},
		'{20'd100,     1'b0, '0},
		'{20'd1000,    1'b0, '0},
		'{20'd12345,   1'b0, '0},
		'{20'h55555,   1'b0, '0},
		'{20'hAAAAA,   1'b0, '0},
		'{20'h80000,   1'b0, '0},
		'{20'h7FFFF,   1'b0, '0},
		'{20'd1048574, 1'b0, '0},
		'{20'd1048575, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	sqs_size_if  size_ch();
	sqs_bound_if bound_ch();

	square_sum_partition_search u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.size_ch  (size_ch),
		.bound_ch (bound_ch)
	);

	bound_rec_t exp_bounds [$];
	int         err_count   = 0;
	int         sizes_sent  = 0;
	int         bounds_seen = 0;
	int         idle_cycles = 0;
	bit         src_gaps    = 1'b1;
	bit         sink_stalls = 1'b1;
	bit         hold_off_req = 1'b0;
	bit         hold_done    = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned square_sum(input longint unsigned x);
		return (x * (x + 1) * (2 * x + 1)) / 6;
	endfunction

	function automatic longint nearest_boundary(input longint prev, input longint n,
		input longint unsigned share);
		longint unsigned target;
		longint unsigned v;
		longint unsigned d_lo;
		longint unsigned d_hi;
		longint          lo;
		longint          hi;
		longint          mid;
		target = square_sum(prev) + share;
		lo = prev;
		hi = n;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			v = square_sum(mid);
			if (v == target)
				return mid;
			if (v < target)
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		if (hi < 0)
			return lo;
		v = square_sum(lo);
		d_lo = (v >= target) ? v - target : target - v;
		v = square_sum(hi);
		d_hi = (v >= target) ? v - target : target - v;
		return (d_lo < d_hi) ? lo : hi;
	endfunction

	function automatic void predict_partition(input logic [N_TOTAL_W-1:0] n_in);
		longint unsigned n;
		longint unsigned share;
		longint          prev;
		bound_rec_t      rec;
		n = longint'(n_in) & ((64'd1 << N_BITS) - 1);
		share = (n * (n + 1) * (2 * n + 1)) / 48;
		prev = 0;
		for (int k = 0; k < NUM_BOUND; k++) begin
			prev = nearest_boundary(prev, n, share);
			rec.idx = bidx_t'(k + 1);
			rec.boundary = bound_t'(prev);
			rec.last = (rec.idx == LAST_IDX);
			exp_bounds.push_back(rec);
		end
	endfunction

	function automatic void note_mismatch(input string what, input longint expv,
		input longint actv);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("%0t mismatch %s: expected %0d actual %0d", $time, what, expv, actv);
	endfunction

	task automatic send_size(input size_row_t row);
		bound_rec_t rec;
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			size_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		size_ch.valid   <= 1'b1;
		size_ch.n_total <= row.n;
		do @(posedge clk); while (!size_ch.ready);
		sizes_sent++;
		if (row.known) begin
			for (int k = 0; k < NUM_BOUND; k++) begin
				rec.idx = bidx_t'(k + 1);
				rec.boundary = row.bounds[k];
				rec.last = (rec.idx == LAST_IDX);
				exp_bounds.push_back(rec);
			end
		end else begin
			predict_partition(row.n);
		end
	endtask

	initial begin : sink_drive
		bound_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				// long hold so the search backs up into the size channel
				bound_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				hold_done = 1'b1;
			end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
				bound_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				bound_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		bound_rec_t rec;
		if (bound_ch.valid && bound_ch.ready) begin
			bounds_seen++;
			if (exp_bounds.size() == 0) begin
				note_mismatch("unexpected boundary transaction", -1, bound_ch.boundary);
			end else begin
				rec = exp_bounds.pop_front();
				if (bound_ch.boundary_index !== rec.idx)
					note_mismatch("boundary_index", rec.idx, bound_ch.boundary_index);
				if (bound_ch.boundary !== rec.boundary)
					note_mismatch("boundary", rec.boundary, bound_ch.boundary);
				if (bound_ch.last !== rec.last)
					note_mismatch("last", rec.last, bound_ch.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((size_ch.valid && size_ch.ready) || (bound_ch.valid && bound_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		size_row_t   row;
		int unsigned w;
		arst_n          <= 1'b0;
		size_ch.valid   <= 1'b0;
		size_ch.n_total <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[i])
			send_size(DIR_ROWS[i]);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == HOLD_AT)
				hold_off_req = 1'b1;
			if (i == RAND_ITEMS - CALM_ITEMS) begin
				src_gaps = 1'b0;
				sink_stalls = 1'b0;
			end
			w = $urandom_range(1, N_TOTAL_W);
			row.n = N_TOTAL_W'($urandom & ((32'd1 << w) - 1));
			row.known = 1'b0;
			row.bounds = '0;
			send_size(row);
		end
		size_ch.valid <= 1'b0;

		while (exp_bounds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (exp_bounds.size() != 0)
			note_mismatch("boundaries never delivered", exp_bounds.size(), 0);
		$display("run: %0d sizes (%0d directed incl. zero and full width), %0d boundaries checked",
			sizes_sent, $size(DIR_ROWS), bounds_seen);
		$display("run: random sizes of every width, idle bursts both sides, long output hold %s, %0d mismatches",
			hold_done ? "done" : "missed", err_count);
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
